// ===== design/hsv_to_rgb_converter_assert.svh =====
// Assertion macros for the HSV to RGB converter.
// Depends on the including module having signals named clock and reset.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication, masked during reset
`define H2R_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("h2r assertion failed");

// next-cycle implication, masked during reset
`define H2R_ASSERT_NXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("h2r assertion failed");

// next-cycle implication, checked through reset as well
`define H2R_ASSERT_RST(lbl, a, b) \
   lbl: assert property (@(posedge clock) (a) |=> (b)) \
      else $error("h2r assertion failed");

`endif

// ===== design/h2r_pkg.sv =====
// Shared constants and types for the HSV to RGB converter.
// No dependencies.
package h2r_pkg;

   localparam int HUE_W              = 16;
   localparam int HUE_POS_W          = 15;
   localparam int HUE_CIRCLE         = 23040;
   localparam int HUE_SECTOR         = 3840;
   localparam int HALF_SECTOR        = 1920;
   localparam int SECTOR_SHIFT       = 8;
   localparam int SECTOR_ODD         = 15;
   localparam int SECTOR_ODD_W       = 4;
   localparam int REM_W              = 12;
   localparam int SECTOR_W           = 3;
   localparam int NUM_STAGES         = 7;
   localparam int COLOR_BITS_DEFAULT = 8;

   typedef enum logic [SECTOR_W-1:0] {
      SEC_RED_YEL   = 3'b000,
      SEC_YEL_GRN   = 3'b001,
      SEC_GRN_CYN   = 3'b010,
      SEC_CYN_BLU   = 3'b011,
      SEC_BLU_MAG   = 3'b100,
      SEC_MAG_RED   = 3'b101,
      SEC_FULL_TURN = 3'b110
   } sector_type;

endpackage

// ===== design/h2r_front.sv =====
// Front stages: hue wrap, sector split, chroma product and first quotient estimate.
// Depends on h2r_pkg.
module h2r_front #(
   parameter int COLOR_BITS = h2r_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [h2r_pkg::HUE_W-1:0]    hue,
   input  logic [COLOR_BITS-1:0]               saturation,
   input  logic [COLOR_BITS-1:0]               brightness,
   output h2r_pkg::sector_type                 sector,
   output logic [h2r_pkg::REM_W-1:0]           rem,
   output logic [2*COLOR_BITS-1:0]             chroma_num,
   output logic [COLOR_BITS-1:0]               chroma_est,
   output logic [COLOR_BITS-1:0]               value
);
   import h2r_pkg::*;

   localparam int PROD_W    = 2 * COLOR_BITS;
   localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((COLOR_MAX - 1) / 2);
   localparam logic signed [HUE_W:0] CIRCLE_S = (HUE_W + 1)'(HUE_CIRCLE);

   logic signed [HUE_W:0]  hue_ext, hue_a, hue_b, hue_c;
   logic [HUE_POS_W-1:0]   hue_pos_ff, hue_pos_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [COLOR_BITS-1:0]  v1_ff, v2_ff;
   sector_type             sector_ff, sector_in;
   logic [HUE_POS_W-1:0]   base;
   logic [HUE_POS_W-1:0]   rem_full;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [PROD_W-1:0]      t_ff, t_in;
   logic [PROD_W:0]        est_sum;
   logic [COLOR_BITS-1:0]  q0_ff, q0_in;

   always_comb begin
      hue_ext    = {hue[HUE_W-1], hue};
      hue_a      = (hue_ext > CIRCLE_S) ? hue_ext - CIRCLE_S : hue_ext;
      hue_b      = (hue_a < 0) ? hue_a + CIRCLE_S : hue_a;
      hue_c      = (hue_b < 0) ? hue_b + CIRCLE_S : hue_b;
      hue_pos_in = hue_c[HUE_POS_W-1:0];
      prod_in    = PROD_W'(saturation) * PROD_W'(brightness);
   end

   always_comb begin
      priority if (hue_pos_ff >= HUE_POS_W'(6 * HUE_SECTOR)) begin
         sector_in = SEC_FULL_TURN;
         base      = HUE_POS_W'(6 * HUE_SECTOR);
      end else if (hue_pos_ff >= HUE_POS_W'(5 * HUE_SECTOR)) begin
         sector_in = SEC_MAG_RED;
         base      = HUE_POS_W'(5 * HUE_SECTOR);
      end else if (hue_pos_ff >= HUE_POS_W'(4 * HUE_SECTOR)) begin
         sector_in = SEC_BLU_MAG;
         base      = HUE_POS_W'(4 * HUE_SECTOR);
      end else if (hue_pos_ff >= HUE_POS_W'(3 * HUE_SECTOR)) begin
         sector_in = SEC_CYN_BLU;
         base      = HUE_POS_W'(3 * HUE_SECTOR);
      end else if (hue_pos_ff >= HUE_POS_W'(2 * HUE_SECTOR)) begin
         sector_in = SEC_GRN_CYN;
         base      = HUE_POS_W'(2 * HUE_SECTOR);
      end else if (hue_pos_ff >= HUE_POS_W'(HUE_SECTOR)) begin
         sector_in = SEC_YEL_GRN;
         base      = HUE_POS_W'(HUE_SECTOR);
      end else begin
         sector_in = SEC_RED_YEL;
         base      = '0;
      end
      rem_full = hue_pos_ff - base;
      rem_in   = rem_full[REM_W-1:0];
      // divide by 2^n-1: estimate q0 = (t + t>>n) >> n, at most one short
      t_in     = prod_ff + ROUND_BIAS;
      est_sum  = {1'b0, t_in} + (PROD_W + 1)'(t_in >> COLOR_BITS);
      q0_in    = est_sum[PROD_W-1:COLOR_BITS];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue_pos_ff <= hue_pos_in;
         prod_ff    <= prod_in;
         v1_ff      <= brightness;
         sector_ff  <= sector_in;
         rem_ff     <= rem_in;
         t_ff       <= t_in;
         q0_ff      <= q0_in;
         v2_ff      <= v1_ff;
      end
   end

   assign sector     = sector_ff;
   assign rem        = rem_ff;
   assign chroma_num = t_ff;
   assign chroma_est = q0_ff;
   assign value      = v2_ff;

endmodule

// ===== design/h2r_secondary.sv =====
// Middle stages: chroma correction, secondary component division and offset m.
// Depends on h2r_pkg.
module h2r_secondary #(
   parameter int COLOR_BITS = h2r_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         advance,
   input  h2r_pkg::sector_type          sector,
   input  logic [h2r_pkg::REM_W-1:0]    rem,
   input  logic [2*COLOR_BITS-1:0]      chroma_num,
   input  logic [COLOR_BITS-1:0]        chroma_est,
   input  logic [COLOR_BITS-1:0]        value,
   output h2r_pkg::sector_type          sector_out,
   output logic [COLOR_BITS-1:0]        chroma,
   output logic [COLOR_BITS-1:0]        second,
   output logic [COLOR_BITS-1:0]        offset
);
   import h2r_pkg::*;

   localparam int PROD_W    = 2 * COLOR_BITS;
   localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;
   localparam int Y_W       = COLOR_BITS + REM_W;
   localparam int W_W       = Y_W - SECTOR_SHIFT;
   localparam int RECIP_W   = COLOR_BITS + 1;
   localparam int RP_W      = W_W + RECIP_W;
   localparam int RSHIFT    = W_W;
   localparam logic [PROD_W-1:0]  MAX_P       = PROD_W'(COLOR_MAX);
   localparam logic [REM_W-1:0]   SECTOR_SPAN = REM_W'(HUE_SECTOR);
   localparam logic [Y_W-1:0]     HALF_Y      = Y_W'(HALF_SECTOR);
   localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'((1 << RSHIFT) / SECTOR_ODD);
   localparam logic [W_W-1:0]     ODD_W       = W_W'(SECTOR_ODD);

   // stage 3
   logic [PROD_W-1:0]     qm3, r3;
   logic [COLOR_BITS-1:0] c3_ff, c3_in, v3_ff;
   logic [REM_W-1:0]      k3_ff, k3_in;
   sector_type            s3_ff;
   // stage 4
   logic [Y_W-1:0]        y4, u4;
   logic [W_W-1:0]        w4_ff, w4_in;
   logic [COLOR_BITS-1:0] c4_ff, v4_ff;
   sector_type            s4_ff;
   // stage 5
   logic [RP_W-1:0]       p5;
   logic [COLOR_BITS-1:0] q5_ff, q5_in, c5_ff, v5_ff;
   logic [W_W-1:0]        w5_ff;
   sector_type            s5_ff;
   // stage 6
   logic [W_W-1:0]        q15, r6;
   logic [COLOR_BITS-1:0] x6_ff, x6_in, m6_ff, m6_in, c6_ff;
   sector_type            s6_ff;

   always_comb begin
      qm3   = (PROD_W'(chroma_est) << COLOR_BITS) - PROD_W'(chroma_est);
      r3    = chroma_num - qm3;
      c3_in = chroma_est + COLOR_BITS'(r3 >= MAX_P);
      k3_in = sector[0] ? SECTOR_SPAN - rem : rem;
   end

   always_comb begin
      y4    = Y_W'(c3_ff) * Y_W'(k3_ff);
      u4    = y4 + HALF_Y;
      w4_in = u4[Y_W-1:SECTOR_SHIFT];
   end

   always_comb begin
      // divide by the odd factor of the sector width: reciprocal, one short at most
      p5    = RP_W'(w4_ff) * RP_W'(RECIP);
      q5_in = p5[RSHIFT+COLOR_BITS-1:RSHIFT];
   end

   always_comb begin
      q15   = (W_W'(q5_ff) << SECTOR_ODD_W) - W_W'(q5_ff);
      r6    = w5_ff - q15;
      x6_in = q5_ff + COLOR_BITS'(r6 >= ODD_W);
      m6_in = v5_ff - c5_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_ff <= c3_in;
         k3_ff <= k3_in;
         v3_ff <= value;
         s3_ff <= sector;
         w4_ff <= w4_in;
         c4_ff <= c3_ff;
         v4_ff <= v3_ff;
         s4_ff <= s3_ff;
         q5_ff <= q5_in;
         w5_ff <= w4_ff;
         c5_ff <= c4_ff;
         v5_ff <= v4_ff;
         s5_ff <= s4_ff;
         x6_ff <= x6_in;
         m6_ff <= m6_in;
         c6_ff <= c5_ff;
         s6_ff <= s5_ff;
      end
   end

   assign sector_out = s6_ff;
   assign chroma     = c6_ff;
   assign second     = x6_ff;
   assign offset     = m6_ff;

endmodule

// ===== design/h2r_mix.sv =====
// Output stage: sector table and offset add into the channel registers.
// Depends on h2r_pkg.
module h2r_mix #(
   parameter int COLOR_BITS = h2r_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   advance,
   input  h2r_pkg::sector_type    sector,
   input  logic [COLOR_BITS-1:0]  chroma,
   input  logic [COLOR_BITS-1:0]  second,
   input  logic [COLOR_BITS-1:0]  offset,
   output logic [COLOR_BITS-1:0]  red,
   output logic [COLOR_BITS-1:0]  green,
   output logic [COLOR_BITS-1:0]  blue
);
   import h2r_pkg::*;

   logic [COLOR_BITS-1:0] r1, g1, b1;
   logic [COLOR_BITS-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   always_comb begin
      unique case (sector)
         SEC_RED_YEL: begin
            r1 = chroma; g1 = second; b1 = '0;
         end
         SEC_YEL_GRN: begin
            r1 = second; g1 = chroma; b1 = '0;
         end
         SEC_GRN_CYN: begin
            r1 = '0; g1 = chroma; b1 = second;
         end
         SEC_CYN_BLU: begin
            r1 = '0; g1 = second; b1 = chroma;
         end
         SEC_BLU_MAG: begin
            r1 = second; g1 = '0; b1 = chroma;
         end
         default: begin
            r1 = chroma; g1 = '0; b1 = second;
         end
      endcase
      red_in   = r1 + offset;
      green_in = g1 + offset;
      blue_in  = b1 + offset;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

// ===== design/hsv_to_rgb_converter.sv =====
// HSV to RGB pixel converter. Takes one pixel per clock while no result waits, and
// returns one RGB pixel per transaction; the pipeline depth is set by the two
// multiply-and-correct reciprocal divisions (chroma and secondary component).
// The whole pipeline holds while the result waits; hue 360 degrees maps to red.
// Depends on h2r_pkg, h2r_front, h2r_secondary, h2r_mix and the assertion header.
module hsv_to_rgb_converter #(
   parameter int COLOR_BITS = h2r_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [h2r_pkg::HUE_W-1:0]   req_hue,
   input  logic [COLOR_BITS-1:0]              req_saturation,
   input  logic [COLOR_BITS-1:0]              req_brightness,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [COLOR_BITS-1:0]              rsp_red,
   output logic [COLOR_BITS-1:0]              rsp_green,
   output logic [COLOR_BITS-1:0]              rsp_blue
);
   import h2r_pkg::*;

`include "hsv_to_rgb_converter_assert.svh"

   logic [NUM_STAGES-1:0]   valid_ff, valid_in;
   logic                    advance;
   sector_type              f_sector, s_sector;
   logic [REM_W-1:0]        f_rem;
   logic [2*COLOR_BITS-1:0] f_num;
   logic [COLOR_BITS-1:0]   f_est, f_value;
   logic [COLOR_BITS-1:0]   s_chroma, s_second, s_offset;

   assign advance   = !valid_ff[NUM_STAGES-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   always_comb begin
      valid_in = advance ? {valid_ff[NUM_STAGES-2:0], req_valid} : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   h2r_front #(.COLOR_BITS(COLOR_BITS)) u_front (
      .clock      (clock),
      .advance    (advance),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .sector     (f_sector),
      .rem        (f_rem),
      .chroma_num (f_num),
      .chroma_est (f_est),
      .value      (f_value)
   );

   h2r_secondary #(.COLOR_BITS(COLOR_BITS)) u_secondary (
      .clock      (clock),
      .advance    (advance),
      .sector     (f_sector),
      .rem        (f_rem),
      .chroma_num (f_num),
      .chroma_est (f_est),
      .value      (f_value),
      .sector_out (s_sector),
      .chroma     (s_chroma),
      .second     (s_second),
      .offset     (s_offset)
   );

   h2r_mix #(.COLOR_BITS(COLOR_BITS)) u_mix (
      .clock   (clock),
      .advance (advance),
      .sector  (s_sector),
      .chroma  (s_chroma),
      .second  (s_second),
      .offset  (s_offset),
      .red     (rsp_red),
      .green   (rsp_green),
      .blue    (rsp_blue)
   );

   `H2R_ASSERT_NXT(a_accept_enters, req_valid && req_ready, valid_ff[0])
   `H2R_ASSERT_NXT(a_stall_freezes, !advance, $stable(valid_ff))
   `H2R_ASSERT_RST(a_reset_clears, reset, valid_ff == '0)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for hsv_to_rgb_converter: directed and random HSV pixels.
// A scoreboard class predicts each RGB result; tasks drive valid, an always block drives ready.
// Depends on h2r_pkg and the converter RTL.

typedef struct packed {
   logic signed [h2r_pkg::HUE_W-1:0]          hue;
   logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0]    sat;
   logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0]    bright;
} hsv_pixel_type;

typedef struct packed {
   logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] red;
   logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] green;
   logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] blue;
} rgb_pixel_type;

class pixel_checker;
   rgb_pixel_type expected_rgb[$];
   int            errors;
   int            pixels_in;
   int            pixels_out;
   int            sector_hits[7];

   function rgb_pixel_type rgb_of_hsv(hsv_pixel_type p);
      int            h, s, v, c, x, m, rem, smax, r, g, b;
      logic [2:0]    sec;
      rgb_pixel_type q;
      smax = (1 << h2r_pkg::COLOR_BITS_DEFAULT) - 1;
      h = int'(p.hue);
      s = int'(p.sat);
      v = int'(p.bright);
      if (h > h2r_pkg::HUE_CIRCLE) h = h - h2r_pkg::HUE_CIRCLE;
      if (h < 0) h = h + h2r_pkg::HUE_CIRCLE;
      if (h < 0) h = h + h2r_pkg::HUE_CIRCLE;
      sec = 3'(h / h2r_pkg::HUE_SECTOR);
      rem = h % h2r_pkg::HUE_SECTOR;
      sector_hits[sec] = sector_hits[sec] + 1;
      c = (2 * v * s + smax) / (2 * smax);
      if (sec[0])
         x = (2 * c * (h2r_pkg::HUE_SECTOR - rem) + h2r_pkg::HUE_SECTOR)
             / (2 * h2r_pkg::HUE_SECTOR);
      else
         x = (2 * c * rem + h2r_pkg::HUE_SECTOR) / (2 * h2r_pkg::HUE_SECTOR);
      m = v - c;
      case (h2r_pkg::sector_type'(sec))
         h2r_pkg::SEC_RED_YEL: begin r = c; g = x; b = 0; end
         h2r_pkg::SEC_YEL_GRN: begin r = x; g = c; b = 0; end
         h2r_pkg::SEC_GRN_CYN: begin r = 0; g = c; b = x; end
         h2r_pkg::SEC_CYN_BLU: begin r = 0; g = x; b = c; end
         h2r_pkg::SEC_BLU_MAG: begin r = x; g = 0; b = c; end
         default:              begin r = c; g = 0; b = x; end
      endcase
      r = (r + m) & smax;
      g = (g + m) & smax;
      b = (b + m) & smax;
      q.red   = r[h2r_pkg::COLOR_BITS_DEFAULT-1:0];
      q.green = g[h2r_pkg::COLOR_BITS_DEFAULT-1:0];
      q.blue  = b[h2r_pkg::COLOR_BITS_DEFAULT-1:0];
      return q;
   endfunction

   function void note_hsv(logic signed [h2r_pkg::HUE_W-1:0] hue,
                          logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] sat,
                          logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] bright);
      hsv_pixel_type p;
      p.hue    = hue;
      p.sat    = sat;
      p.bright = bright;
      expected_rgb.insert(expected_rgb.size(), rgb_of_hsv(p));
      pixels_in = pixels_in + 1;
   endfunction

   function void check_rgb(logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] red,
                           logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] green,
                           logic [h2r_pkg::COLOR_BITS_DEFAULT-1:0] blue);
      rgb_pixel_type want;
      pixels_out = pixels_out + 1;
      if (expected_rgb.size() == 0) begin
         errors = errors + 1;
         if (errors <= 10)
            $display("unexpected rgb transaction: %0d %0d %0d", red, green, blue);
         return;
      end
      want = expected_rgb.pop_front();
      if (want.red !== red || want.green !== green || want.blue !== blue) begin
         errors = errors + 1;
         if (errors <= 10)
            $display("rgb mismatch at result %0d: expected %0d %0d %0d, got %0d %0d %0d",
                     pixels_out, want.red, want.green, want.blue, red, green, blue);
      end
   endfunction

   function int pending();
      return expected_rgb.size();
   endfunction

   function void flush_leftover();
      if (expected_rgb.size() != 0) begin
         errors = errors + expected_rgb.size();
         $display("%0d expected rgb transactions never arrived", expected_rgb.size());
         expected_rgb.delete();
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB          = h2r_pkg::COLOR_BITS_DEFAULT;
   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN       = 24;
   localparam int NUM_RANDOM  = 1130;

   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_ready;
   logic signed [h2r_pkg::HUE_W-1:0] req_hue      = '0;
   logic [CB-1:0]                  req_saturation = '0;
   logic [CB-1:0]                  req_brightness = '0;
   logic                           rsp_valid;
   logic                           rsp_ready      = 1'b0;
   logic [CB-1:0]                  rsp_red;
   logic [CB-1:0]                  rsp_green;
   logic [CB-1:0]                  rsp_blue;

   pixel_checker  chk = new();
   hsv_pixel_type pixel_list[$];
   int            num_directed;
   int            idle_cycles    = 0;
   int            ready_mode     = 0;
   int            ready_mode_left = 0;
   int            ready_phase    = 0;

   hsv_to_rgb_converter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            chk.note_hsv(req_hue, req_saturation, req_brightness);
         if (rsp_valid && rsp_ready)
            chk.check_rgb(rsp_red, rsp_green, rsp_blue);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stall pattern: always ready, coin flip, one in four, long stalls
   always @(posedge clock) begin
      ready_phase <= ready_phase + 1;
      if (ready_mode_left == 0) begin
         ready_mode      <= $urandom_range(0, 3);
         ready_mode_left <= $urandom_range(40, 300);
      end else begin
         ready_mode_left <= ready_mode_left - 1;
      end
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= (ready_phase % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic hsv_pixel_type make_pixel(int hue, int sat, int bright);
      hsv_pixel_type p;
      p.hue    = 16'(hue);
      p.sat    = CB'(sat);
      p.bright = CB'(bright);
      return p;
   endfunction

   function automatic void queue_pixel(hsv_pixel_type p);
      pixel_list.insert(pixel_list.size(), p);
   endfunction

   task automatic build_directed();
      int k;
      queue_pixel(make_pixel(0, 255, 255));
      queue_pixel(make_pixel(-32768, 255, 255));
      queue_pixel(make_pixel(32767, 255, 255));
      queue_pixel(make_pixel(23040, 255, 255));
      queue_pixel(make_pixel(23041, 200, 180));
      queue_pixel(make_pixel(-1, 255, 255));
      queue_pixel(make_pixel(-23040, 128, 200));
      queue_pixel(make_pixel(-23041, 255, 128));
      for (k = 1; k < 6; k++) begin
         queue_pixel(make_pixel(k * h2r_pkg::HUE_SECTOR, 255, 255));
         queue_pixel(make_pixel(k * h2r_pkg::HUE_SECTOR - 1, 255, 255));
      end
      queue_pixel(make_pixel(h2r_pkg::HUE_SECTOR + h2r_pkg::HALF_SECTOR, 255, 255));
      queue_pixel(make_pixel(h2r_pkg::HALF_SECTOR, 1, 255));
      queue_pixel(make_pixel(9000, 0, 255));
      queue_pixel(make_pixel(15000, 255, 0));
      queue_pixel(make_pixel(5000, 0, 0));
      queue_pixel(make_pixel(-12345, 170, 85));
      num_directed = pixel_list.size();
   endtask

   task automatic build_random();
      int i, sel, hue, sat, bright;
      for (i = 0; i < NUM_RANDOM; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 2)
            hue = int'($urandom_range(0, 16)) * h2r_pkg::HUE_SECTOR - 30720
                  + int'($urandom_range(0, 8)) - 4;
         else
            hue = $urandom_range(0, 65535);
         sat    = $urandom_range(0, 255);
         bright = $urandom_range(0, 255);
         if (sel == 9) begin
            sat    = ($urandom_range(0, 1) != 0) ? 255 : $urandom_range(0, 1);
            bright = ($urandom_range(0, 1) != 0) ? 254 + $urandom_range(0, 1) : 0;
         end
         queue_pixel(make_pixel(hue, sat, bright));
      end
   endtask

   task automatic drive_pixel(hsv_pixel_type p);
      req_valid      <= 1'b1;
      req_hue        <= p.hue;
      req_saturation <= p.sat;
      req_brightness <= p.bright;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (chk.pending() != 0);
   endtask

   task automatic send_all();
      int i, burst_left, gap;
      burst_left = 0;
      for (i = 0; i < pixel_list.size(); i++) begin
         // hold off until the pipeline is empty after the directed part and midway
         if (i == num_directed || i == num_directed + NUM_RANDOM / 2) begin
            drain_results();
         end else if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap        = $urandom_range(0, 12);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (burst_left != 0) burst_left = burst_left - 1;
         drive_pixel(pixel_list[i]);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      build_directed();
      build_random();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_all();
      do @(posedge clock); while (chk.pending() != 0);
      repeat (DRAIN) @(posedge clock);
      chk.flush_leftover();
      $display("converted %0d pixels (%0d directed), %0d results, %0d mismatches",
               chk.pixels_in, num_directed, chk.pixels_out, chk.errors);
      $display("hue sectors hit 0..6: %0d %0d %0d %0d %0d %0d %0d",
               chk.sector_hits[0], chk.sector_hits[1], chk.sector_hits[2],
               chk.sector_hits[3], chk.sector_hits[4], chk.sector_hits[5],
               chk.sector_hits[6]);
      if (chk.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/h2r_pkg.sv
design/h2r_front.sv
design/h2r_secondary.sv
design/h2r_mix.sv
design/hsv_to_rgb_converter.sv
test/tb.sv
